/* rtl/bmptc_pkg.sv */
`default_nettype none
package bmptc_pkg;

   typedef struct packed {
      logic [4:0]  bpp;
      logic        use_565;
      logic        allow_red;
      logic [9:0]  vis_w;
      logic [9:0]  vis_h;
      logic [11:0] row_bytes;
      logic        bottom_up;
   } cfg_type;

   typedef struct packed {
      logic        use_pal;
      logic        pal_ok;
      logic        red_en;
      logic [1:0]  color;
      logic [9:0]  column;
      logic [8:0]  row;
      logic        last;
      logic        frame;
   } pix_type;

   localparam logic [2:0] REG_BPP       = 3'd0;
   localparam logic [2:0] REG_USE_565   = 3'd1;
   localparam logic [2:0] REG_ALLOW_RED = 3'd2;
   localparam logic [2:0] REG_VIS_W     = 3'd3;
   localparam logic [2:0] REG_VIS_H     = 3'd4;
   localparam logic [2:0] REG_ROW_BYTES = 3'd5;
   localparam logic [2:0] REG_BOTTOM_UP = 3'd6;

   localparam logic [4:0] BPP_1  = 5'd1;
   localparam logic [4:0] BPP_4  = 5'd4;
   localparam logic [4:0] BPP_8  = 5'd8;
   localparam logic [4:0] BPP_16 = 5'd16;
   localparam logic [4:0] BPP_24 = 5'd24;

   localparam logic ACT_PALETTE = 1'b0;
   localparam logic ACT_DATA    = 1'b1;

   localparam logic [1:0] COLOR_WHITE = 2'd0;
   localparam logic [1:0] COLOR_BLACK = 2'd1;
   localparam logic [1:0] COLOR_RED   = 2'd2;

   localparam logic [7:0] WHITE_LEVEL = 8'h80;
   localparam logic [7:0] COLOR_LEVEL = 8'hF0;
   localparam logic [9:0] WHITE_SUM   = 10'h180;

   function automatic logic is_whitish(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b, input logic red_en);
      logic [9:0] sum;
      sum = {2'b00, r} + {2'b00, g} + {2'b00, b};
      if (red_en) begin
         return (r > WHITE_LEVEL) && (g > WHITE_LEVEL) && (b > WHITE_LEVEL);
      end
      return sum > WHITE_SUM;
   endfunction

   function automatic logic is_colored(input logic [7:0] r, input logic [7:0] g,
                                       input logic [7:0] b);
      return (r > COLOR_LEVEL) || ((g > COLOR_LEVEL) && (b > COLOR_LEVEL));
   endfunction

   function automatic logic [1:0] pick_color(input logic white, input logic colored,
                                             input logic red_en);
      if (white) begin
         return COLOR_WHITE;
      end
      if (colored && red_en) begin
         return COLOR_RED;
      end
      return COLOR_BLACK;
   endfunction

endpackage
`default_nettype wire

/* rtl/bmptc_pal_ram.sv */
`default_nettype none
module bmptc_pal_ram #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [1:0]    wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [1:0]    rd_data
);

   logic [1:0] mem [DEPTH];
   logic [1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* rtl/bmptc_unpack.sv */
`default_nettype none
module bmptc_unpack #(
   parameter int MAX_WIDTH    = 800,
   parameter int MAX_HEIGHT   = 512,
   parameter int PALETTE_SIZE = 256,
   parameter int PAL_AW       = 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire bmptc_pkg::cfg_type  cfg,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire logic                in_action,
   input  wire logic [7:0]          in_index,
   input  wire logic [7:0]          in_blue,
   input  wire logic [7:0]          in_green,
   input  wire logic [7:0]          in_red,
   input  wire logic [7:0]          in_data,
   input  wire logic                out_free,
   output logic                     emit,
   output bmptc_pkg::pix_type       pix,
   output logic                     rd_en,
   output logic [PAL_AW-1:0]        rd_addr,
   output logic                     wr_en,
   output logic [PAL_AW-1:0]        wr_addr,
   output logic [1:0]               wr_data
);
   import bmptc_pkg::*;

   logic        valid_ff, valid_in;
   logic        act_ff, act_in;
   logic [7:0]  idx_ff, idx_in;
   logic [7:0]  blue_ff, blue_in;
   logic [7:0]  green_ff, green_in;
   logic [7:0]  red_ff, red_in;
   logic [7:0]  data_ff, data_in;
   logic [2:0]  slot_ff, slot_in;
   logic [15:0] held_ff, held_in;
   logic [1:0]  phase_ff, phase_in;
   logic [9:0]  col_ff, col_in;
   logic [11:0] rbc_ff, rbc_in;
   logic [9:0]  row_ff, row_in;

   logic        accept, step, done, red_en, col_ok, pal_ok;
   logic [9:0]  w10, h10, eff_w, eff_h, row_eff, disp_row;
   logic [10:0] row_next;
   logic [11:0] rbc_next;
   logic [2:0]  last_slot;
   logic [7:0]  pidx, pr, pg, pb;

   always_comb begin
      w10 = (cfg.vis_w == 10'd0) ? 10'd1 : cfg.vis_w;
      h10 = (cfg.vis_h == 10'd0) ? 10'd1 : cfg.vis_h;
      eff_w = ({3'b000, w10} > 13'(MAX_WIDTH)) ? 10'(MAX_WIDTH) : w10;
      eff_h = ({3'b000, h10} > 13'(MAX_HEIGHT)) ? 10'(MAX_HEIGHT) : h10;
      red_en = cfg.allow_red && (cfg.bpp != BPP_1);
      row_eff = (row_ff >= eff_h) ? 10'd0 : row_ff;
      disp_row = cfg.bottom_up ? (eff_h - 10'd1 - row_eff) : row_eff;
      col_ok = col_ff < eff_w;
      step = valid_ff && out_free;

      case (cfg.bpp)
         BPP_1: begin
            last_slot = 3'd7;
            pidx = {7'b0, data_ff[3'd7 - slot_ff]};
         end
         BPP_4: begin
            last_slot = 3'd1;
            pidx = slot_ff[0] ? {4'b0, data_ff[3:0]} : {4'b0, data_ff[7:4]};
         end
         default: begin
            last_slot = 3'd0;
            pidx = data_ff;
         end
      endcase
      pal_ok = {1'b0, pidx} < 9'(PALETTE_SIZE);

      if (cfg.bpp == BPP_16) begin
         pb = {held_ff[4:0], 3'b000};
         if (cfg.use_565) begin
            pg = {data_ff[2:0], held_ff[7:5], 2'b00};
            pr = {data_ff[7:3], 3'b000};
         end else begin
            pg = {data_ff[1:0], held_ff[7:5], 3'b000};
            pr = {data_ff[6:2], 3'b000};
         end
      end else begin
         pb = held_ff[7:0];
         pg = held_ff[15:8];
         pr = data_ff;
      end

      pix.use_pal = 1'b0;
      pix.pal_ok  = pal_ok;
      pix.red_en  = red_en;
      pix.color   = pick_color(is_whitish(pr, pg, pb, red_en), is_colored(pr, pg, pb),
                               red_en);
      pix.column  = col_ff;
      pix.row     = disp_row[8:0];
      pix.last    = 1'b1;
      pix.frame   = (col_ff == eff_w - 10'd1) && (row_eff == eff_h - 10'd1);

      valid_in = valid_ff;
      act_in   = act_ff;
      idx_in   = idx_ff;
      blue_in  = blue_ff;
      green_in = green_ff;
      red_in   = red_ff;
      data_in  = data_ff;
      slot_in  = slot_ff;
      held_in  = held_ff;
      phase_in = phase_ff;
      col_in   = col_ff;
      rbc_in   = rbc_ff;
      row_in   = row_ff;
      emit     = 1'b0;
      rd_en    = 1'b0;
      wr_en    = 1'b0;
      done     = 1'b0;
      rd_addr  = pidx[PAL_AW-1:0];
      wr_addr  = idx_ff[PAL_AW-1:0];
      wr_data  = {is_whitish(red_ff, green_ff, blue_ff, red_en),
                  is_colored(red_ff, green_ff, blue_ff)};
      rbc_next = rbc_ff + 12'd1;
      row_next = {1'b0, row_eff} + 11'd1;

      if (step) begin
         if (act_ff == ACT_PALETTE) begin
            wr_en = {1'b0, idx_ff} < 9'(PALETTE_SIZE);
            done = 1'b1;
         end else begin
            case (cfg.bpp)
               BPP_1, BPP_4, BPP_8: begin
                  pix.use_pal = 1'b1;
                  pix.last = (slot_ff == last_slot) || (col_ff == eff_w - 10'd1);
                  if (col_ok) begin
                     emit = 1'b1;
                     rd_en = 1'b1;
                     col_in = col_ff + 10'd1;
                  end
                  if (slot_ff == last_slot) begin
                     done = 1'b1;
                  end else begin
                     slot_in = slot_ff + 3'd1;
                  end
               end
               BPP_16, BPP_24: begin
                  done = 1'b1;
                  if (phase_ff == 2'd0) begin
                     held_in = {8'h00, data_ff};
                     phase_in = 2'd1;
                  end else if ((cfg.bpp == BPP_24) && (phase_ff == 2'd1)) begin
                     held_in = {data_ff, held_ff[7:0]};
                     phase_in = 2'd2;
                  end else begin
                     held_in = 16'h0000;
                     phase_in = 2'd0;
                     if (col_ok) begin
                        emit = 1'b1;
                        col_in = col_ff + 10'd1;
                     end
                  end
               end
               default: begin
                  done = 1'b1;
               end
            endcase
            if (done) begin
               row_in = row_eff;
               rbc_in = rbc_next;
               if (rbc_next == cfg.row_bytes) begin
                  rbc_in = 12'd0;
                  phase_in = 2'd0;
                  held_in = 16'h0000;
                  col_in = 10'd0;
                  row_in = (row_next >= {1'b0, eff_h}) ? 10'd0 : row_next[9:0];
               end
            end
         end
      end

      in_ready = !valid_ff || done;
      accept = in_valid && in_ready;
      if (done) begin
         valid_in = 1'b0;
         slot_in = 3'd0;
      end
      if (accept) begin
         valid_in = 1'b1;
         slot_in  = 3'd0;
         act_in   = in_action;
         idx_in   = in_index;
         blue_in  = in_blue;
         green_in = in_green;
         red_in   = in_red;
         data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         slot_ff  <= 3'd0;
         held_ff  <= 16'h0000;
         phase_ff <= 2'd0;
         col_ff   <= 10'd0;
         rbc_ff   <= 12'd0;
         row_ff   <= 10'd0;
      end else begin
         valid_ff <= valid_in;
         slot_ff  <= slot_in;
         held_ff  <= held_in;
         phase_ff <= phase_in;
         col_ff   <= col_in;
         rbc_ff   <= rbc_in;
         row_ff   <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff   <= act_in;
      idx_ff   <= idx_in;
      blue_ff  <= blue_in;
      green_ff <= green_in;
      red_ff   <= red_in;
      data_ff  <= data_in;
   end

   a_slot_idle: assert property (@(posedge clock) disable iff (reset)
      !valid_ff |-> slot_ff == 3'd0)
      else $error("slot counter left nonzero while idle");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff != 2'd3)
      else $error("byte phase out of range");

   a_wr_no_emit: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !emit && !rd_en)
      else $error("palette write overlaps a pixel");

endmodule
`default_nettype wire

/* rtl/bmptc_out.sv */
`default_nettype none
module bmptc_out (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                emit,
   input  wire bmptc_pkg::pix_type  pix,
   input  wire logic [1:0]          pal_data,
   output logic                     out_free,
   input  wire logic                rsp_ready,
   output logic                     rsp_valid,
   output logic [1:0]               rsp_color,
   output logic [9:0]               rsp_column,
   output logic [8:0]               rsp_row,
   output logic                     rsp_last,
   output logic                     rsp_frame
);
   import bmptc_pkg::*;

   logic    p1_valid_ff, p1_valid_in;
   pix_type meta_ff, meta_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic [1:0] color_ff, color_in;
   logic [9:0] column_ff, column_in;
   logic [8:0] row_ff, row_in;
   logic    last_ff, last_in, frame_ff, frame_in;
   logic    p1_go;

   always_comb begin
      p1_go = p1_valid_ff && (!rsp_valid_ff || rsp_ready);
      out_free = !p1_valid_ff || p1_go;

      p1_valid_in = emit ? 1'b1 : (p1_go ? 1'b0 : p1_valid_ff);
      meta_in = emit ? pix : meta_ff;

      rsp_valid_in = p1_go ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      color_in  = color_ff;
      column_in = column_ff;
      row_in    = row_ff;
      last_in   = last_ff;
      frame_in  = frame_ff;
      if (p1_go) begin
         if (meta_ff.use_pal) begin
            color_in = pick_color(pal_data[1] && meta_ff.pal_ok,
                                  pal_data[0] && meta_ff.pal_ok, meta_ff.red_en);
         end else begin
            color_in = meta_ff.color;
         end
         column_in = meta_ff.column;
         row_in    = meta_ff.row;
         last_in   = meta_ff.last;
         frame_in  = meta_ff.frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff  <= p1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      meta_ff   <= meta_in;
      color_ff  <= color_in;
      column_ff <= column_in;
      row_ff    <= row_in;
      last_ff   <= last_in;
      frame_ff  <= frame_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_color  = color_ff;
   assign rsp_column = column_ff;
   assign rsp_row    = row_ff;
   assign rsp_last   = last_ff;
   assign rsp_frame  = frame_ff;

   a_p1_hold: assert property (@(posedge clock) disable iff (reset)
      p1_valid_ff && !p1_go |=> p1_valid_ff && $stable(meta_ff))
      else $error("stalled pixel lost");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("pixel pushed into a full stage");

   a_frame_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && frame_ff |-> last_ff)
      else $error("frame end without run end");

endmodule
`default_nettype wire

/* rtl/bmp_pixel_to_tricolor_top.sv */
// BMP pixel unpacker for a three-color (white, black, red) panel.
// req_*: one item per handshake. tuser = 0 loads a palette entry (index, blue,
// green, red in tdata), tuser = 1 carries one raw row byte in file order,
// padding included. Palette entries are classified into white/red bits as
// they are written to the palette RAM.
// rsp_*: one item per visible pixel: color, column, display row; tlast marks
// the last pixel caused by one input byte, tuser the last pixel of the frame.
// csr_*: write-only registers; write them only while the block is idle (not enforced).
// Each byte is registered in the unpacker, each pixel then in p1 and in rsp.
// Throughput, without rsp stalls: one byte per cycle at depths 8, 16 and 24;
// depths 4 and 1 hold a byte for all its pixels, one palette RAM lookup per cycle.
// Bytes past the visible width and palette loads yield no rsp item.
// Reset: registers return to their defaults and the row counters clear; the
// palette holds no defined contents until loaded.
// A stalled rsp holds its item; the pipeline fills and req_tready drops.
`default_nettype none
module bmp_pixel_to_tricolor_top #(
   parameter int MAX_WIDTH    = 800,
   parameter int PALETTE_SIZE = 256,
   parameter int MAX_HEIGHT   = 512
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // palette_index, blue_in, green_in, red_in, data_byte
   input  wire logic [39:0] req_tdata,
   // action
   input  wire logic        req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // pixel_color, column, display_row, zero fill
   output logic [23:0]      rsp_tdata,
   output logic             rsp_tlast,
   // frame_done
   output logic             rsp_tuser,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [11:0] csr_wdata
);
   import bmptc_pkg::*;

   localparam int PAL_AW = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;

   cfg_type cfg_ff, cfg_in;
   pix_type pix;
   logic    emit, out_free, rd_en, wr_en;
   logic [PAL_AW-1:0] rd_addr, wr_addr;
   logic [1:0] wr_data, rd_data, color;
   logic [9:0] column;
   logic [8:0] row;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_BPP:       cfg_in.bpp = csr_wdata[4:0];
            REG_USE_565:   cfg_in.use_565 = csr_wdata[0];
            REG_ALLOW_RED: cfg_in.allow_red = csr_wdata[0];
            REG_VIS_W:     cfg_in.vis_w = csr_wdata[9:0];
            REG_VIS_H:     cfg_in.vis_h = csr_wdata[9:0];
            REG_ROW_BYTES: cfg_in.row_bytes = csr_wdata;
            REG_BOTTOM_UP: cfg_in.bottom_up = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bpp       <= BPP_24;
         cfg_ff.use_565   <= 1'b0;
         cfg_ff.allow_red <= 1'b1;
         cfg_ff.vis_w     <= 10'd296;
         cfg_ff.vis_h     <= 10'd128;
         cfg_ff.row_bytes <= 12'd888;
         cfg_ff.bottom_up <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bmptc_unpack #(
      .MAX_WIDTH    (MAX_WIDTH),
      .MAX_HEIGHT   (MAX_HEIGHT),
      .PALETTE_SIZE (PALETTE_SIZE),
      .PAL_AW       (PAL_AW)
   ) u_unpack (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_action (req_tuser),
      .in_index  (req_tdata[7:0]),
      .in_blue   (req_tdata[15:8]),
      .in_green  (req_tdata[23:16]),
      .in_red    (req_tdata[31:24]),
      .in_data   (req_tdata[39:32]),
      .out_free  (out_free),
      .emit      (emit),
      .pix       (pix),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

   bmptc_pal_ram #(
      .DEPTH (PALETTE_SIZE),
      .AW    (PAL_AW)
   ) u_pal_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bmptc_out u_out (
      .clock      (clock),
      .reset      (reset),
      .emit       (emit),
      .pix        (pix),
      .pal_data   (rd_data),
      .out_free   (out_free),
      .rsp_ready  (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_color  (color),
      .rsp_column (column),
      .rsp_row    (row),
      .rsp_last   (rsp_tlast),
      .rsp_frame  (rsp_tuser)
   );

   assign rsp_tdata = {3'b000, row, column, color};

endmodule
`default_nettype wire

/* sim/bmp_pixel_to_tricolor_top_test.sv */
`timescale 1ns / 100ps
module bmp_pixel_to_tricolor_top_test;
   import bmptc_pkg::*;

   localparam int MAX_W = 800;
   localparam int MAX_H = 512;
   localparam int SETTLE_CYCLES = 40;
   localparam int QUIET_LIMIT = 4000;
   localparam int RANDOM_ITEMS = 52;
   localparam int ERROR_PRINTS = 40;

   typedef struct packed {
      logic [1:0] color;
      logic [9:0] column;
      logic [8:0] row;
      logic       last;
      logic       frame;
   } pixel_type;

   class tricolor_scoreboard;
      logic [4:0]  bpp;
      bit          use_565;
      bit          allow_red;
      bit          bottom_up;
      int unsigned vis_w;
      int unsigned vis_h;
      int unsigned row_bytes;
      bit          pal_white[256];
      bit          pal_red[256];
      int unsigned held;
      int unsigned phase;
      int unsigned col;
      int unsigned rbc;
      int unsigned row;
      pixel_type   pending[$];
      pixel_type   run[$];
      pixel_type   want;
      int unsigned items;
      int unsigned loads;
      int unsigned pixels;
      int unsigned frames;
      int unsigned errors;

      function new();
         bpp = BPP_24;
         use_565 = 0;
         allow_red = 1;
         vis_w = 296;
         vis_h = 128;
         row_bytes = 888;
         bottom_up = 1;
         held = 0;
         phase = 0;
         col = 0;
         rbc = 0;
         row = 0;
      endfunction

      function void set_reg(logic [2:0] ix, logic [11:0] v);
         case (ix)
            REG_BPP:       bpp = v[4:0];
            REG_USE_565:   use_565 = v[0];
            REG_ALLOW_RED: allow_red = v[0];
            REG_VIS_W:     vis_w = v[9:0];
            REG_VIS_H:     vis_h = v[9:0];
            REG_ROW_BYTES: row_bytes = v;
            REG_BOTTOM_UP: bottom_up = v[0];
            default: ;
         endcase
      endfunction

      function bit red_on();
         return allow_red && bpp != BPP_1;
      endfunction

      function bit whitish(int unsigned r, int unsigned g, int unsigned b);
         if (red_on()) begin
            return r > 'h80 && g > 'h80 && b > 'h80;
         end
         return r + g + b > 3 * 'h80;
      endfunction

      function bit colored(int unsigned r, int unsigned g, int unsigned b);
         return r > 'hF0 || (g > 'hF0 && b > 'hF0);
      endfunction

      function logic [1:0] shade(bit white, bit col_hit);
         if (white) begin
            return COLOR_WHITE;
         end
         if (col_hit && red_on()) begin
            return COLOR_RED;
         end
         return COLOR_BLACK;
      endfunction

      function int unsigned eff_w();
         if (vis_w == 0) return 1;
         if (vis_w > MAX_W) return MAX_W;
         return vis_w;
      endfunction

      function int unsigned eff_h();
         if (vis_h == 0) return 1;
         if (vis_h > MAX_H) return MAX_H;
         return vis_h;
      endfunction

      function void put_pixel(logic [1:0] c);
         int unsigned w;
         int unsigned h;
         pixel_type p;
         w = eff_w();
         h = eff_h();
         if (col < w) begin
            p.color = c;
            p.column = 10'(col);
            p.row = 9'(bottom_up ? h - 1 - row : row);
            p.last = 1'b0;
            p.frame = (col == w - 1) && (row == h - 1);
            run.push_back(p);
            col++;
         end
      endfunction

      function void rgb_pixel(int unsigned r, int unsigned g, int unsigned b);
         put_pixel(shade(whitish(r, g, b), colored(r, g, b)));
      endfunction

      function void note_item(logic act, logic [39:0] d);
         int unsigned idx;
         int unsigned db;
         int unsigned dep;
         int unsigned ix;
         int unsigned lsb;
         int unsigned r;
         int unsigned g;
         int unsigned b;
         idx = d[7:0];
         db = d[39:32];
         run.delete();
         items++;
         if (act == ACT_PALETTE) begin
            pal_white[idx] = whitish(d[31:24], d[23:16], d[15:8]);
            pal_red[idx] = colored(d[31:24], d[23:16], d[15:8]);
            loads++;
            return;
         end
         if (row >= eff_h()) row = 0;
         case (bpp)
            BPP_1, BPP_4, BPP_8: begin
               dep = bpp;
               for (int k = 0; k < 8 / dep; k++) begin
                  ix = (db >> (8 - dep - k * dep)) & ((1 << dep) - 1);
                  put_pixel(shade(pal_white[ix], pal_red[ix]));
               end
            end
            BPP_16: begin
               if (phase == 0) begin
                  held = db;
                  phase = 1;
               end else begin
                  lsb = held & 'hFF;
                  b = (lsb & 'h1F) << 3;
                  if (use_565) begin
                     g = ((db & 'h07) << 5) | ((lsb & 'hE0) >> 3);
                     r = db & 'hF8;
                  end else begin
                     g = ((db & 'h03) << 6) | ((lsb & 'hE0) >> 2);
                     r = (db & 'h7C) << 1;
                  end
                  phase = 0;
                  held = 0;
                  rgb_pixel(r, g, b);
               end
            end
            BPP_24: begin
               if (phase == 0) begin
                  held = db;
                  phase = 1;
               end else if (phase == 1) begin
                  held = (held & 'hFF) | (db << 8);
                  phase = 2;
               end else begin
                  b = held & 'hFF;
                  g = (held >> 8) & 'hFF;
                  phase = 0;
                  held = 0;
                  rgb_pixel(db, g, b);
               end
            end
            default: ;
         endcase
         rbc = (rbc + 1) & 'hFFF;
         if (rbc == row_bytes) begin
            rbc = 0;
            phase = 0;
            held = 0;
            col = 0;
            row++;
            if (row >= eff_h()) row = 0;
         end
         if (run.size() > 0) run[run.size() - 1].last = 1'b1;
         foreach (run[i]) pending.push_back(run[i]);
      endfunction

      task report(string msg);
         errors++;
         if (errors <= ERROR_PRINTS) $display("error: %s", msg);
      endtask

      task compare_field(string fname, logic [9:0] got, logic [9:0] exp_val);
         if (got !== exp_val) begin
            report($sformatf("%s got %0h want %0h at column %0d row %0d",
                             fname, got, exp_val, want.column, want.row));
         end
      endtask

      task check(pixel_type got);
         if (pending.size() == 0) begin
            report($sformatf("unexpected pixel at column %0d row %0d", got.column, got.row));
            return;
         end
         want = pending.pop_front();
         pixels++;
         if (want.frame) frames++;
         compare_field("color", got.color, want.color);
         compare_field("column", got.column, want.column);
         compare_field("row", got.row, want.row);
         compare_field("last", got.last, want.last);
         compare_field("frame_done", got.frame, want.frame);
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [11:0] csr_wdata;

   tricolor_scoreboard sb = new();
   bit pal_loaded[256];
   int send_idle;
   int recv_idle;
   int quiet;
   int csr_writes;

   bmp_pixel_to_tricolor_top dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check(pixel_type'({rsp_tdata[1:0], rsp_tdata[11:2], rsp_tdata[20:12],
                               rsp_tlast, rsp_tuser}));
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
         if (quiet >= QUIET_LIMIT) begin
            $display("bmp_pixel_to_tricolor_top: mismatch");
            $finish;
         end
      end
   end

   task automatic send_item(logic act, logic [39:0] d);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      sb.note_item(act, d);
      @(negedge clock);
   endtask

   function automatic logic [7:0] channel_value();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'h80;
         2: return 8'h81;
         3: return 8'hF0;
         4: return 8'hF1;
         5: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic load_entry(logic [7:0] idx);
      pal_loaded[idx] = 1'b1;
      send_item(ACT_PALETTE, {8'($urandom_range(0, 255)), channel_value(), channel_value(),
                              channel_value(), idx});
   endtask

   task automatic send_data(logic [7:0] value);
      send_item(ACT_DATA, {value, 32'($urandom)});
   endtask

   // build palette bytes only from loaded entries
   function automatic logic [7:0] gen_byte(logic [4:0] depth);
      int unsigned dep;
      int unsigned ix;
      int unsigned cand[$];
      logic [7:0] v;
      if (depth == BPP_24) return channel_value();
      if (depth != BPP_1 && depth != BPP_4 && depth != BPP_8) return 8'($urandom_range(0, 255));
      dep = depth;
      for (int i = 0; i < (1 << dep); i++) begin
         if (pal_loaded[i]) cand.push_back(i);
      end
      v = 8'h00;
      for (int k = 0; k < 8 / dep; k++) begin
         ix = cand[$urandom_range(0, cand.size() - 1)];
         v = v | 8'(ix << (8 - dep - k * dep));
      end
      return v;
   endfunction

   task automatic write_reg(logic [2:0] ix, logic [11:0] v);
      csr_we <= 1'b1;
      csr_index <= ix;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      sb.set_reg(ix, v);
      csr_writes++;
      @(negedge clock);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic run_frame(logic [4:0] depth, int unsigned w, int unsigned h,
                            int unsigned rb, int unsigned extra);
      int unsigned nbytes;
      settle();
      write_reg(REG_BPP, 12'(depth));
      write_reg(REG_USE_565, 12'($urandom_range(0, 1)));
      write_reg(REG_ALLOW_RED, 12'($urandom_range(0, 1)));
      write_reg(REG_VIS_W, 12'(w));
      write_reg(REG_VIS_H, 12'(h));
      write_reg(REG_BOTTOM_UP, 12'($urandom_range(0, 1)));
      if (depth == BPP_1) begin
         load_entry(8'd0);
         load_entry(8'd1);
      end else if (depth == BPP_4) begin
         repeat ($urandom_range(2, 4)) load_entry(8'($urandom_range(0, 15)));
      end else if (depth == BPP_8) begin
         repeat ($urandom_range(2, 5)) load_entry(8'($urandom_range(0, 255)));
      end
      // close any open row by setting the row length one byte past the bytes sent
      if (sb.rbc != 0) begin
         settle();
         write_reg(REG_ROW_BYTES, 12'(sb.rbc + 1));
         send_data(gen_byte(depth));
      end
      settle();
      write_reg(REG_ROW_BYTES, 12'(rb));
      nbytes = rb * h + extra;
      repeat (nbytes) begin
         if ($urandom_range(0, 11) == 0) load_entry(8'($urandom_range(0, 255)));
         send_data(gen_byte(depth));
      end
   endtask

   initial begin
      int unsigned start;
      int unsigned sel;
      int unsigned dep_bits;
      int unsigned w;
      int unsigned h;
      int unsigned rb;
      int unsigned natural_bytes;
      int unsigned extra;
      logic [4:0] depth;

      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      quiet = 0;
      csr_writes = 0;
      send_idle = 28;
      recv_idle = 48;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings, depth 24: white, red, cyan, threshold black
      send_data(8'hFF); send_data(8'hFF); send_data(8'hFF);
      send_data(8'h00); send_data(8'h00); send_data(8'hFF);
      send_data(8'hF1); send_data(8'hF1); send_data(8'h00);
      send_data(8'h81); send_data(8'h81); send_data(8'h80);
      send_data(8'h81); send_data(8'h81);
      // switch to depth 16 with two bytes held
      settle();
      write_reg(REG_BPP, 12'(BPP_16));
      send_data(8'hFF);
      // zero width and height, 565, red off, top-down
      settle();
      write_reg(REG_USE_565, 12'd1);
      write_reg(REG_ALLOW_RED, 12'd0);
      write_reg(REG_VIS_W, 12'd0);
      write_reg(REG_VIS_H, 12'd0);
      write_reg(REG_BOTTOM_UP, 12'd0);
      write_reg(REG_ROW_BYTES, 12'(sb.rbc + 1));
      send_data(8'h00);
      send_data(8'h1F); send_data(8'hFF);
      send_data(8'hE0); send_data(8'h07);
      // oversized width and height, 4096-byte rows
      settle();
      write_reg(REG_BPP, 12'(BPP_24));
      write_reg(REG_ALLOW_RED, 12'd1);
      write_reg(REG_VIS_W, 12'd1023);
      write_reg(REG_VIS_H, 12'd1023);
      write_reg(REG_ROW_BYTES, 12'd0);
      write_reg(REG_BOTTOM_UP, 12'd1);
      send_data(8'h00); send_data(8'h00); send_data(8'hFF);
      // unsupported depth
      settle();
      write_reg(REG_BPP, 12'd31);
      send_data(8'h5A);
      load_entry(8'd255);
      load_entry(8'd128);

      // full-width row at depth 1 reaches the last column
      run_frame(BPP_1, 1023, 1, 100, 0);
      start = sb.items;
      send_idle = 48;
      recv_idle = 28;
      while (sb.items - start < RANDOM_ITEMS || send_idle != 0) begin
         if (sb.items - start >= RANDOM_ITEMS / 2) begin
            send_idle = 0;
            recv_idle = 0;
         end else begin
            send_idle = 48;
            recv_idle = 28;
         end
         sel = $urandom_range(0, 11);
         if (sel < 2) depth = BPP_1;
         else if (sel < 4) depth = BPP_4;
         else if (sel < 6) depth = BPP_8;
         else if (sel < 9) depth = BPP_16;
         else if (sel < 11) depth = BPP_24;
         else begin
            do depth = 5'($urandom_range(0, 31));
            while (depth == BPP_1 || depth == BPP_4 || depth == BPP_8 ||
                   depth == BPP_16 || depth == BPP_24);
         end
         dep_bits = (sel == 11) ? 8 : depth;
         w = $urandom_range(1, 6);
         h = $urandom_range(1, 3);
         natural_bytes = (w * dep_bits + 7) / 8;
         rb = ((natural_bytes + 3) / 4) * 4;
         if ($urandom_range(0, 4) == 0) rb = natural_bytes + $urandom_range(0, 2);
         if ($urandom_range(0, 4) == 0) w = w + $urandom_range(1, 3);
         extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, rb > 1 ? rb - 1 : 1) : 0;
         run_frame(depth, w, h, rb, extra);
      end

      settle();
      $display("covered %0d items (%0d palette loads) and %0d register writes",
               sb.items, sb.loads, csr_writes);
      $display("checked %0d pixels including %0d frame ends", sb.pixels, sb.frames);
      if (sb.errors == 0) begin
         $display("bmp_pixel_to_tricolor_top: match");
      end else begin
         $display("bmp_pixel_to_tricolor_top: mismatch");
      end
      $finish;
   end

endmodule
